// File: rtl/core/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int TAG_BITS   = 8;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int CMD_W  = 2;
  localparam int TAGF_W = 8;
  localparam int SIZE_W = 11;
  localparam int BLK_W  = 10;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd3;

  typedef logic [TAG_BITS-1:0] tag_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TAGF_W-1:0] owner_tag;
    logic [SIZE_W-1:0] size_blocks;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] start_block;
    logic [BLK_W-1:0] end_block;
    logic [ST_W-1:0]  status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch a new word, reset scan state
    logic scan;      // walk the owner table
    logic fill;      // write the claimed run
    logic zero;      // clear the tail after compaction
    logic clear;     // clearing pass after reset
    logic load_out;  // capture the result word
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early_bad;   // request settled without a scan
    logic alloc_hit;   // free run long enough found
    logic query_end;   // first run of the tag has ended
    logic scan_last;   // last entry evaluated
    logic fill_last;   // last entry of the run written
    logic zero_last;   // tail clearing finished
    logic clear_last;  // last entry cleared
    logic is_compact;  // current word is a compaction
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ffba_datapath.sv
// Datapath: owner table memory, scan counters, run tracking and result register.
`default_nettype none

module ffba_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ffba_pkg::req_t      req_i,
  input  ffba_pkg::dp_cmd_t   cmd_i,
  output ffba_pkg::dp_sts_t   sts_o,
  output ffba_pkg::rsp_t      rsp_o
);
  import ffba_pkg::*;

  localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] N_LAST = CNT_W'(NUM_BLOCKS - 1);

  tag_t owner_mem [NUM_BLOCKS];

  logic [CMD_W-1:0]  cmd_q;
  tag_t              tag_q;
  logic [SIZE_W-1:0] size_q;

  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              rd_vld_q;
  logic [ADDR_W-1:0] rd_idx_q;
  tag_t              rdata_q;

  logic [CNT_W-1:0]  run_len_q, run_len_d;
  logic [ADDR_W-1:0] run_start_q, run_start_d;
  logic [ADDR_W-1:0] fill_end_q, fill_end_d;
  logic              alloc_ok_q, alloc_ok_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] first_q, first_d;
  logic [ADDR_W-1:0] last_q, last_d;
  rsp_t              out_q;

  logic              rd_en;
  logic              eval;
  logic              hit_tag;
  logic              is_free_blk;
  logic [CNT_W-1:0]  ns_len;
  logic [ADDR_W-1:0] ns_start;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  tag_t              wdata;
  logic              early_bad;
  logic [ST_W-1:0]   early_st;
  rsp_t              res;

  assign rd_en       = cmd_i.scan && (idx_q < N_CNT);
  assign eval        = cmd_i.scan && rd_vld_q;
  assign hit_tag     = (rdata_q == tag_q);
  assign is_free_blk = (rdata_q == '0);
  assign ns_len      = run_len_q + CNT_W'(1);
  assign ns_start    = (run_len_q == '0) ? rd_idx_q : run_start_q;

  // Requests settled without touching the table
  always_comb begin
    early_bad = 1'b0;
    early_st  = ST_OK;
    case (cmd_q)
      CMD_ALLOC: begin
        if (tag_q == '0 || size_q == '0) begin
          early_bad = 1'b1;
          early_st  = ST_INVALID;
        end else if (int'(size_q) > NUM_BLOCKS) begin
          early_bad = 1'b1;
          early_st  = ST_NOSPACE;
        end
      end
      CMD_FREE: begin
        if (tag_q == '0) begin
          early_bad = 1'b1;
          early_st  = ST_INVALID;
        end
      end
      default: ;
    endcase
  end

  // Scan evaluation and counters
  always_comb begin
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    fill_end_d  = fill_end_q;
    alloc_ok_d  = alloc_ok_q;
    found_d     = found_q;
    first_d     = first_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = ptr_q[ADDR_W-1:0];
    wdata       = '0;

    if (cmd_i.start) begin
      idx_d      = '0;
      ptr_d      = '0;
      run_len_d  = '0;
      alloc_ok_d = 1'b0;
      found_d    = 1'b0;
      first_d    = '0;
      last_d     = '0;
    end

    if (rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end

    if (eval) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (is_free_blk) begin
            run_start_d = ns_start;
            run_len_d   = ns_len;
            if (ns_len >= CNT_W'(size_q)) begin
              alloc_ok_d = 1'b1;
              fill_end_d = rd_idx_q;
              ptr_d      = {1'b0, ns_start};
            end
          end else begin
            run_len_d = '0;
          end
        end
        CMD_QUERY: begin
          if (hit_tag) begin
            if (!found_q) begin
              first_d = rd_idx_q;
            end
            found_d = 1'b1;
            last_d  = rd_idx_q;
          end
        end
        CMD_FREE: begin
          if (hit_tag) begin
            found_d = 1'b1;
            we      = 1'b1;
            waddr   = rd_idx_q;
            wdata   = '0;
          end
        end
        CMD_COMPACT: begin
          // Pack used entries at the write pointer, it never passes the read side
          if (!is_free_blk) begin
            we    = 1'b1;
            waddr = ptr_q[ADDR_W-1:0];
            wdata = rdata_q;
            ptr_d = ptr_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.fill) begin
      we    = 1'b1;
      wdata = tag_q;
      ptr_d = ptr_q + CNT_W'(1);
    end

    if (cmd_i.zero && (ptr_q < N_CNT)) begin
      we    = 1'b1;
      wdata = '0;
      ptr_d = ptr_q + CNT_W'(1);
    end

    if (cmd_i.clear) begin
      we    = 1'b1;
      wdata = '0;
      ptr_d = ptr_q + CNT_W'(1);
    end
  end

  // Result word
  always_comb begin
    res = '0;
    if (early_bad) begin
      res.status = early_st;
    end else begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (alloc_ok_q) begin
            res.start_block = BLK_W'(run_start_q);
            res.end_block   = BLK_W'(fill_end_q);
            res.status      = ST_OK;
          end else begin
            res.status = ST_NOSPACE;
          end
        end
        CMD_QUERY: begin
          if (found_q) begin
            res.start_block = BLK_W'(first_q);
            res.end_block   = BLK_W'(last_q);
            res.status      = ST_OK;
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        CMD_FREE: begin
          res.status = found_q ? ST_OK : ST_NOTFOUND;
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      owner_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= owner_mem[idx_q[ADDR_W-1:0]];
      rd_idx_q <= idx_q[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q  <= req_i.command;
      tag_q  <= req_i.owner_tag[TAG_BITS-1:0];
      size_q <= req_i.size_blocks;
    end
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    fill_end_q  <= fill_end_d;
    alloc_ok_q  <= alloc_ok_d;
    found_q     <= found_d;
    first_q     <= first_d;
    last_q      <= last_d;
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign sts_o.early_bad  = early_bad;
  assign sts_o.alloc_hit  = eval && (cmd_q == CMD_ALLOC) && is_free_blk &&
                            (ns_len >= CNT_W'(size_q));
  assign sts_o.query_end  = eval && (cmd_q == CMD_QUERY) && found_q && !hit_tag;
  assign sts_o.scan_last  = eval && ({1'b0, rd_idx_q} == N_LAST);
  assign sts_o.fill_last  = (ptr_q[ADDR_W-1:0] == fill_end_q);
  assign sts_o.zero_last  = (ptr_q >= N_LAST);
  assign sts_o.clear_last = (ptr_q == N_LAST);
  assign sts_o.is_compact = (cmd_q == CMD_COMPACT);

  assign rsp_o = out_q;

endmodule

`default_nettype wire

// File: rtl/core/ffba_ctrl.sv
// Controller: sequences clearing, scan, fill and tail clearing, owns the handshakes.
`default_nettype none

module ffba_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ffba_pkg::dp_cmd_t   cmd_o,
  input  ffba_pkg::dp_sts_t   sts_i
);
  import ffba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_ZERO  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = sts_i.early_bad ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.alloc_hit) begin
          state_d = S_FILL;
        end else if (sts_i.query_end) begin
          state_d = S_DONE;
        end else if (sts_i.scan_last) begin
          state_d = sts_i.is_compact ? S_ZERO : S_DONE;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_ZERO: begin
        cmd_o.zero = 1'b1;
        if (sts_i.zero_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the result register is free
        if (can_load) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass re-entered");

  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.alloc_hit |-> (state_q == S_SCAN))
    else $error("allocation hit outside of scan");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted word not checked");

endmodule

`default_nettype wire

// File: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller plus datapath.
// Sequence: requests rejected up front skip the scan; others scan the table, then an
//   allocate that hits fills its run and a compact clears the tail before the result loads.
// Flow: one word at a time; a new word is taken only in the idle state, after the last
//   result has been loaded, and every scan goes through the single read port of the table.
// Reset: asynchronous, active low; a clearing pass over every block follows,
//   with in_ready_o low until every block is free.
`default_nettype none

module first_fit_block_allocator (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ffba_pkg::req_t      in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ffba_pkg::rsp_t      out_data_o
);
  import ffba_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  ffba_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: bench/first_fit_block_allocator_test.sv
// Self-checking bench for the first-fit block allocator: directed table, then random words.
`timescale 1ns / 100ps

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int NUM_DIRECTED   = 25;
  localparam int RANDOM_WORDS   = 515;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES  = 2 * NUM_BLOCKS + 16;

  typedef struct packed {
    req_t word;
    logic typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  tag_t     owner_model [NUM_BLOCKS];
  rsp_t     pending_rsps [$];
  dir_row_t dir_table [NUM_DIRECTED];
  int       burst_left = 0;
  int       fail_count = 0;
  int       cmd_count [4];
  int       status_count [4];

  first_fit_block_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  initial begin : reset_gen
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one word to the owner table copy and return the result it must produce.
  function automatic rsp_t predict_response(input req_t word);
    rsp_t rsp;
    tag_t tag;
    tag_t held;
    int   run_start;
    int   run_len;
    int   wr;
    logic hit;
    logic done;
    rsp       = '0;
    tag       = word.owner_tag[TAG_BITS-1:0];
    run_start = 0;
    run_len   = 0;
    wr        = 0;
    hit       = 1'b0;
    done      = 1'b0;
    case (word.command)
      CMD_ALLOC: begin
        if (tag == '0 || word.size_blocks == '0) begin
          rsp.status = ST_INVALID;
        end else begin
          // Oversized requests never reach a matching run length.
          rsp.status = ST_NOSPACE;
          for (int b = 0; b < NUM_BLOCKS && !done; b++) begin
            if (owner_model[b] != '0) begin
              run_len = 0;
            end else begin
              if (run_len == 0) run_start = b;
              run_len++;
              if (run_len == word.size_blocks) begin
                for (int c = run_start; c <= b; c++) owner_model[c] = tag;
                rsp.start_block = run_start[BLK_W-1:0];
                rsp.end_block   = b[BLK_W-1:0];
                rsp.status      = ST_OK;
                done            = 1'b1;
              end
            end
          end
        end
      end
      CMD_QUERY: begin
        for (int b = 0; b < NUM_BLOCKS && !done; b++) begin
          if (owner_model[b] == tag) begin
            if (!hit) rsp.start_block = b[BLK_W-1:0];
            hit           = 1'b1;
            rsp.end_block = b[BLK_W-1:0];
          end else if (hit) begin
            done = 1'b1;
          end
        end
        rsp.status = hit ? ST_OK : ST_NOTFOUND;
      end
      CMD_FREE: begin
        if (tag == '0) begin
          rsp.status = ST_INVALID;
        end else begin
          for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (owner_model[b] == tag) begin
              owner_model[b] = '0;
              hit            = 1'b1;
            end
          end
          rsp.status = hit ? ST_OK : ST_NOTFOUND;
        end
      end
      CMD_COMPACT: begin
        for (int b = 0; b < NUM_BLOCKS; b++) begin
          if (owner_model[b] != '0) begin
            held            = owner_model[b];
            owner_model[b]  = '0;
            owner_model[wr] = held;
            wr++;
          end
        end
        rsp.status = ST_OK;
      end
    endcase
    return rsp;
  endfunction

  function automatic dir_row_t make_row(input logic [CMD_W-1:0] cmd, input int tag,
                                        input int size, input logic typed,
                                        input logic [ST_W-1:0] st, input int first,
                                        input int last);
    dir_row_t r;
    r.word.command     = cmd;
    r.word.owner_tag   = tag[TAGF_W-1:0];
    r.word.size_blocks = size[SIZE_W-1:0];
    r.typed            = typed;
    r.rsp.start_block  = first[BLK_W-1:0];
    r.rsp.end_block    = last[BLK_W-1:0];
    r.rsp.status       = st;
    return r;
  endfunction

  // Mostly small runs from a small tag pool so that queries and frees hit.
  function automatic req_t random_word();
    req_t word;
    int   pick;
    int   tag_val;
    int   size_val;
    pick = $urandom_range(99);
    if (pick < 40) word.command = CMD_ALLOC;
    else if (pick < 62) word.command = CMD_QUERY;
    else if (pick < 90) word.command = CMD_FREE;
    else word.command = CMD_COMPACT;
    tag_val = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 12);
    pick = $urandom_range(99);
    if (pick < 70) size_val = $urandom_range(1, 32);
    else if (pick < 88) size_val = $urandom_range(1, 256);
    else if (pick < 95) size_val = $urandom_range(257, NUM_BLOCKS);
    else if (pick < 98) size_val = 0;
    else size_val = $urandom_range(NUM_BLOCKS + 1, 2047);
    word.owner_tag   = tag_val[TAGF_W-1:0];
    word.size_blocks = size_val[SIZE_W-1:0];
    return word;
  endfunction

  // Send one word; called at a rising edge, returns at the edge that accepts it.
  task automatic send_word(input req_t word, input logic typed, input rsp_t typed_rsp,
                           input logic drain);
    rsp_t predicted;
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_rsps.size() != 0) @(posedge clk);
    end else if (burst_left == 0) begin
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2500) : $urandom_range(1, 16))
        @(posedge clk);
    end else begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    predicted = predict_response(word);
    if (typed) predicted = typed_rsp;
    pending_rsps.push_back(predicted);
    cmd_count[word.command]++;
    status_count[predicted.status]++;
  endtask

  initial begin : stimulus
    for (int b = 0; b < NUM_BLOCKS; b++) owner_model[b] = '0;
    for (int k = 0; k < 4; k++) begin
      cmd_count[k]    = 0;
      status_count[k] = 0;
    end
    dir_table[0]  = make_row(CMD_QUERY,   0,    0,    1'b1, ST_OK,       0, NUM_BLOCKS - 1);
    dir_table[1]  = make_row(CMD_QUERY,   170,  0,    1'b1, ST_NOTFOUND, 0, 0);
    dir_table[2]  = make_row(CMD_FREE,    85,   0,    1'b1, ST_NOTFOUND, 0, 0);
    dir_table[3]  = make_row(CMD_FREE,    0,    0,    1'b1, ST_INVALID,  0, 0);
    dir_table[4]  = make_row(CMD_ALLOC,   0,    4,    1'b1, ST_INVALID,  0, 0);
    dir_table[5]  = make_row(CMD_ALLOC,   1,    0,    1'b1, ST_INVALID,  0, 0);
    dir_table[6]  = make_row(CMD_ALLOC,   1,    1025, 1'b1, ST_NOSPACE,  0, 0);
    dir_table[7]  = make_row(CMD_ALLOC,   1,    1,    1'b1, ST_OK,       0, 0);
    dir_table[8]  = make_row(CMD_QUERY,   1,    2047, 1'b1, ST_OK,       0, 0);
    dir_table[9]  = make_row(CMD_ALLOC,   2,    3,    1'b0, ST_OK,       0, 0);
    dir_table[10] = make_row(CMD_ALLOC,   255,  1,    1'b0, ST_OK,       0, 0);
    dir_table[11] = make_row(CMD_ALLOC,   3,    2,    1'b0, ST_OK,       0, 0);
    // Open a one-block hole, skip it with a longer run, then fill it.
    dir_table[12] = make_row(CMD_FREE,    255,  0,    1'b0, ST_OK,       0, 0);
    dir_table[13] = make_row(CMD_ALLOC,   4,    2,    1'b0, ST_OK,       0, 0);
    dir_table[14] = make_row(CMD_ALLOC,   6,    1,    1'b0, ST_OK,       0, 0);
    dir_table[15] = make_row(CMD_FREE,    2,    0,    1'b0, ST_OK,       0, 0);
    dir_table[16] = make_row(CMD_QUERY,   0,    0,    1'b0, ST_OK,       0, 0);
    dir_table[17] = make_row(CMD_ALLOC,   9,    1024, 1'b0, ST_OK,       0, 0);
    dir_table[18] = make_row(CMD_COMPACT, 0,    0,    1'b1, ST_OK,       0, 0);
    dir_table[19] = make_row(CMD_QUERY,   3,    0,    1'b0, ST_OK,       0, 0);
    // Fill the table completely after compaction.
    dir_table[20] = make_row(CMD_ALLOC,   10,   1018, 1'b0, ST_OK,       0, 0);
    dir_table[21] = make_row(CMD_QUERY,   0,    0,    1'b0, ST_OK,       0, 0);
    dir_table[22] = make_row(CMD_ALLOC,   11,   1,    1'b0, ST_OK,       0, 0);
    dir_table[23] = make_row(CMD_COMPACT, 255,  2047, 1'b1, ST_OK,       0, 0);
    dir_table[24] = make_row(CMD_FREE,    10,   0,    1'b0, ST_OK,       0, 0);

    wait (rst_n === 1'b1);
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].rsp, 1'b0);
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_word(random_word(), 1'b0, '0, i == 0 || i == RANDOM_WORDS / 2);
    in_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d allocate, %0d query, %0d free, %0d compact.",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[CMD_ALLOC], cmd_count[CMD_QUERY], cmd_count[CMD_FREE],
             cmd_count[CMD_COMPACT]);
    $display("Statuses seen: %0d ok, %0d no space, %0d not found, %0d invalid.",
             status_count[ST_OK], status_count[ST_NOSPACE], status_count[ST_NOTFOUND],
             status_count[ST_INVALID]);
    if (fail_count == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

  initial begin : response_check
    rsp_t want;
    int   ready_left;
    int   stall_left;
    ready_left = 0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_rsps.size() == 0) begin
          $error("result word with nothing expected: start_block %0d end_block %0d status %0d",
                 out_data.start_block, out_data.end_block, out_data.status);
          fail_count++;
        end else begin
          want = pending_rsps.pop_front();
          if (out_data.start_block !== want.start_block) begin
            $error("start_block: expected %0d, actual %0d", want.start_block,
                   out_data.start_block);
            fail_count++;
          end
          if (out_data.end_block !== want.end_block) begin
            $error("end_block: expected %0d, actual %0d", want.end_block, out_data.end_block);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
      // Ready stretches alternate with stalls; now and then a long one of either.
      if (ready_left > 0) begin
        ready_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        ready_left = ($urandom_range(7) == 0) ? $urandom_range(2000, 5000)
                                              : $urandom_range(0, 63);
        stall_left = ($urandom_range(63) == 0) ? $urandom_range(100, 1500)
                                               : $urandom_range(1, 12);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("No word moved for %0d cycles, %0d results outstanding.", WATCHDOG_LIMIT,
             pending_rsps.size());
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_datapath.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
bench/first_fit_block_allocator_test.sv
